### sv/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define CHK_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

### sv/tlbpt_pkg.sv
// Shared constants and types for the demand-paging translator.
// No dependencies; used by the cell, chain, top-level and checker files.
package tlbpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int FRAME_COUNT = 256;
  localparam int PAGE_W      = 8;
  localparam int FRAME_W     = 8;
  localparam int OFF_W       = 8;
  localparam int ADDR_W      = PAGE_W + OFF_W;
  localparam int TLB_POS_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int TLB_CNT_W   = $clog2(TLB_ENTRIES + 1);
  localparam int FCNT_W      = $clog2(FRAME_COUNT + 1);
  localparam int PAGE_DEPTH  = 2 ** PAGE_W;
  localparam int FRAME_DEPTH = 2 ** FRAME_W;

  // One TLB entry as held by a cell
  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlb_entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_t;

  typedef enum logic [1:0] {
    CHAIN_IDLE,
    CHAIN_TOUCH,
    CHAIN_DROP
  } chain_op_t;

  // Command to the chain: touch shifts cells 0..pos toward the tail and
  // loads cell 0; drop removes cell pos and closes the gap.
  typedef struct packed {
    chain_op_t          op;
    logic [TLB_POS_W-1:0] pos;
    tlb_entry_t         load;
  } chain_cmd_t;

  typedef struct packed {
    logic                 hit;
    logic [TLB_POS_W-1:0] hit_pos;
    tlb_entry_t           hit_entry;
    logic                 drop_hit;
    logic [TLB_POS_W-1:0] drop_pos;
  } chain_stat_t;

endpackage

### sv/tlbpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/tlbpt_cell.sv
// One TLB cell: holds an entry, compares it, takes a neighbor's entry.
// Depends on tlbpt_pkg.
module tlbpt_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  tlbpt_pkg::cell_op_t            op,
  input  tlbpt_pkg::tlb_entry_t          prev_in,
  input  tlbpt_pkg::tlb_entry_t          next_in,
  input  logic [tlbpt_pkg::PAGE_W-1:0]   query_page,
  input  logic [tlbpt_pkg::FRAME_W-1:0]  query_frame,
  output tlbpt_pkg::tlb_entry_t          entry,
  output logic                           page_match,
  output logic                           frame_match
);

  logic                          valid;
  logic [tlbpt_pkg::PAGE_W-1:0]  page;
  logic [tlbpt_pkg::FRAME_W-1:0] frame;

  // Valid bit, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        tlbpt_pkg::CELL_FROM_PREV: valid <= prev_in.valid;
        tlbpt_pkg::CELL_FROM_NEXT: valid <= next_in.valid;
        default:                   valid <= valid;
      endcase
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    case (op)
      tlbpt_pkg::CELL_FROM_PREV: begin
        page  <= prev_in.page;
        frame <= prev_in.frame;
      end
      tlbpt_pkg::CELL_FROM_NEXT: begin
        page  <= next_in.page;
        frame <= next_in.frame;
      end
      default: begin
        page  <= page;
        frame <= frame;
      end
    endcase
  end

  assign entry       = {valid, page, frame};
  assign page_match  = valid && (page == query_page);
  assign frame_match = valid && (frame == query_frame);

endmodule

### sv/tlbpt_chain.sv
// TLB as a row of cells in recency order: cell 0 is most recent.
// Depends on tlbpt_pkg and tlbpt_cell.
module tlbpt_chain (
  input  logic                           clk,
  input  logic                           rst,
  input  tlbpt_pkg::chain_cmd_t          cmd,
  input  logic [tlbpt_pkg::PAGE_W-1:0]   query_page,
  input  logic [tlbpt_pkg::FRAME_W-1:0]  query_frame,
  output tlbpt_pkg::chain_stat_t         stat
);

  tlbpt_pkg::tlb_entry_t ent     [tlbpt_pkg::TLB_ENTRIES];
  tlbpt_pkg::tlb_entry_t prev_in [tlbpt_pkg::TLB_ENTRIES];
  tlbpt_pkg::tlb_entry_t next_in [tlbpt_pkg::TLB_ENTRIES];
  tlbpt_pkg::cell_op_t   ops     [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::TLB_ENTRIES-1:0] pm;
  logic [tlbpt_pkg::TLB_ENTRIES-1:0] fm;

  // Neighbor wiring and per-cell operation
  always_comb begin
    for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
      prev_in[i] = (i == 0) ? cmd.load : ent[(i == 0) ? 0 : i - 1];
      next_in[i] = (i == tlbpt_pkg::TLB_ENTRIES - 1) ? '0 :
                   ent[(i == tlbpt_pkg::TLB_ENTRIES - 1) ? i : i + 1];
      case (cmd.op)
        tlbpt_pkg::CHAIN_TOUCH:
          ops[i] = (tlbpt_pkg::TLB_POS_W'(i) <= cmd.pos) ?
                   tlbpt_pkg::CELL_FROM_PREV : tlbpt_pkg::CELL_HOLD;
        tlbpt_pkg::CHAIN_DROP:
          ops[i] = (tlbpt_pkg::TLB_POS_W'(i) >= cmd.pos) ?
                   tlbpt_pkg::CELL_FROM_NEXT : tlbpt_pkg::CELL_HOLD;
        default:
          ops[i] = tlbpt_pkg::CELL_HOLD;
      endcase
    end
  end

  for (genvar g = 0; g < tlbpt_pkg::TLB_ENTRIES; g++) begin : g_cell
    tlbpt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (ops[g]),
      .prev_in     (prev_in[g]),
      .next_in     (next_in[g]),
      .query_page  (query_page),
      .query_frame (query_frame),
      .entry       (ent[g]),
      .page_match  (pm[g]),
      .frame_match (fm[g])
    );
  end

  // Lowest matching position wins
  always_comb begin
    stat = '0;
    for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
      if (pm[i]) begin
        stat.hit       = 1'b1;
        stat.hit_pos   = tlbpt_pkg::TLB_POS_W'(i);
        stat.hit_entry = ent[i];
      end
      if (fm[i]) begin
        stat.drop_hit = 1'b1;
        stat.drop_pos = tlbpt_pkg::TLB_POS_W'(i);
      end
    end
  end

endmodule

### sv/tlb_page_table_lru_translator.sv
// Top level of the demand-paging translator with an LRU TLB.
// Depends on tlbpt_pkg, tlbpt_chain, tlbpt_ram.
//
//   channel | direction | handshake          | payload
//   in      | sink      | in_valid/in_stall  | virtual_address
//   out     | source    | out_valid/out_stall| physical_address, tlb_hit, fault_flag,
//           |           |                    | fill_page, evicted_valid, evicted_page
//
// The frame recency list (linked list held in prev/next RAMs, one write
// port each) is brought up to date before a result is registered.
// One request is in work at a time; a finished result may wait in the
// output register while the next request is accepted.
// Synchronous reset clears the TLB valid bits, page table valid bits and counts.
module tlb_page_table_lru_translator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tlbpt_pkg::ADDR_W-1:0]  virtual_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tlbpt_pkg::ADDR_W-1:0]  physical_address,
  output logic                          tlb_hit,
  output logic                          fault_flag,
  output logic [tlbpt_pkg::PAGE_W-1:0]  fill_page,
  output logic                          evicted_valid,
  output logic [tlbpt_pkg::PAGE_W-1:0]  evicted_page
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_TBL, S_EVICT, S_T0, S_T1, S_T2, S_FILL, S_DONE
  } state_t;

  state_t state;

  logic [tlbpt_pkg::PAGE_W-1:0]    page_q;
  logic [tlbpt_pkg::OFF_W-1:0]     off_q;
  logic [tlbpt_pkg::FRAME_W-1:0]   frame_q;
  logic                            hit_q;
  logic                            fault_q;
  logic                            evv_q;
  logic [tlbpt_pkg::PAGE_W-1:0]    evp_q;
  logic [tlbpt_pkg::FRAME_W-1:0]   head;
  logic [tlbpt_pkg::FRAME_W-1:0]   tail;
  logic [tlbpt_pkg::FCNT_W-1:0]    frames_used;
  logic [tlbpt_pkg::TLB_CNT_W-1:0] tlb_used;
  logic [tlbpt_pkg::PAGE_DEPTH-1:0] table_valid;

  tlbpt_pkg::chain_cmd_t  cmd;
  tlbpt_pkg::chain_stat_t stat;

  logic                          tf_we, ow_we, nx_we, pv_we;
  logic [tlbpt_pkg::FRAME_W-1:0] tf_wdata, tf_rdata;
  logic [tlbpt_pkg::FRAME_W-1:0] ow_waddr;
  logic [tlbpt_pkg::PAGE_W-1:0]  ow_rdata;
  logic [tlbpt_pkg::FRAME_W-1:0] nx_waddr, nx_wdata, nx_rdata;
  logic [tlbpt_pkg::FRAME_W-1:0] pv_waddr, pv_wdata, pv_rdata;
  logic [tlbpt_pkg::FRAME_W-1:0] alloc_frame;
  logic                          frames_left;
  logic                          tlb_full;
  logic                          out_free;

  assign alloc_frame = frames_used[tlbpt_pkg::FRAME_W-1:0];
  assign frames_left = (frames_used < tlbpt_pkg::FCNT_W'(tlbpt_pkg::FRAME_COUNT));
  assign tlb_full    = (tlb_used == tlbpt_pkg::TLB_CNT_W'(tlbpt_pkg::TLB_ENTRIES));
  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != S_IDLE);

  tlbpt_chain u_chain (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .query_page  (page_q),
    .query_frame (frame_q),
    .stat        (stat)
  );

  // Page table frame numbers
  tlbpt_ram #(.WIDTH(tlbpt_pkg::FRAME_W), .DEPTH(tlbpt_pkg::PAGE_DEPTH)) u_table (
    .clk (clk), .we (tf_we), .waddr (page_q), .wdata (tf_wdata),
    .raddr (page_q), .rdata (tf_rdata)
  );

  // Reverse map: frame to owning page
  tlbpt_ram #(.WIDTH(tlbpt_pkg::PAGE_W), .DEPTH(tlbpt_pkg::FRAME_DEPTH)) u_owner (
    .clk (clk), .we (ow_we), .waddr (ow_waddr), .wdata (page_q),
    .raddr (tail), .rdata (ow_rdata)
  );

  // Frame recency list, toward LRU
  tlbpt_ram #(.WIDTH(tlbpt_pkg::FRAME_W), .DEPTH(tlbpt_pkg::FRAME_DEPTH)) u_next (
    .clk (clk), .we (nx_we), .waddr (nx_waddr), .wdata (nx_wdata),
    .raddr (frame_q), .rdata (nx_rdata)
  );

  // Frame recency list, toward MRU
  tlbpt_ram #(.WIDTH(tlbpt_pkg::FRAME_W), .DEPTH(tlbpt_pkg::FRAME_DEPTH)) u_prev (
    .clk (clk), .we (pv_we), .waddr (pv_waddr), .wdata (pv_wdata),
    .raddr (frame_q), .rdata (pv_rdata)
  );

  // RAM write ports and chain command
  always_comb begin
    tf_we    = 1'b0;
    tf_wdata = frame_q;
    ow_we    = 1'b0;
    ow_waddr = frame_q;
    nx_we    = 1'b0;
    nx_waddr = frame_q;
    nx_wdata = head;
    pv_we    = 1'b0;
    pv_waddr = head;
    pv_wdata = frame_q;
    cmd      = '0;
    cmd.op   = tlbpt_pkg::CHAIN_IDLE;
    case (state)
      S_LOOK: begin
        if (stat.hit) begin
          cmd.op   = tlbpt_pkg::CHAIN_TOUCH;
          cmd.pos  = stat.hit_pos;
          cmd.load = stat.hit_entry;
        end
      end
      S_TBL: begin
        if (!table_valid[page_q] && frames_left) begin
          tf_we    = 1'b1;
          tf_wdata = alloc_frame;
          ow_we    = 1'b1;
          ow_waddr = alloc_frame;
        end
      end
      S_EVICT: begin
        tf_we = 1'b1;
        ow_we = 1'b1;
        if (stat.drop_hit) begin
          cmd.op  = tlbpt_pkg::CHAIN_DROP;
          cmd.pos = stat.drop_pos;
        end
      end
      S_T1: begin
        // unlink: next[prev] = next, prev[next] = prev
        nx_we    = 1'b1;
        nx_waddr = pv_rdata;
        nx_wdata = nx_rdata;
        pv_we    = (frame_q != tail);
        pv_waddr = nx_rdata;
        pv_wdata = pv_rdata;
      end
      S_T2: begin
        // push front
        nx_we = 1'b1;
        pv_we = 1'b1;
      end
      S_FILL: begin
        cmd.op         = tlbpt_pkg::CHAIN_TOUCH;
        cmd.pos        = tlb_full ? tlbpt_pkg::TLB_POS_W'(tlbpt_pkg::TLB_ENTRIES - 1) :
                                    tlb_used[tlbpt_pkg::TLB_POS_W-1:0];
        cmd.load.valid = 1'b1;
        cmd.load.page  = page_q;
        cmd.load.frame = frame_q;
      end
      default: ;
    endcase
  end

  // Sequencer with registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      frames_used <= '0;
      tlb_used    <= '0;
      table_valid <= '0;
    end else begin
      // result taken; S_DONE loads the next one itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            page_q  <= virtual_address[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFF_W];
            off_q   <= virtual_address[tlbpt_pkg::OFF_W-1:0];
            hit_q   <= 1'b0;
            fault_q <= 1'b0;
            evv_q   <= 1'b0;
            evp_q   <= '0;
            state   <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (stat.hit) begin
            hit_q   <= 1'b1;
            frame_q <= stat.hit_entry.frame;
            state   <= S_T0;
          end else begin
            state <= S_TBL;
          end
        end
        S_TBL: begin
          if (table_valid[page_q]) begin
            frame_q <= tf_rdata;
            state   <= S_T0;
          end else begin
            fault_q             <= 1'b1;
            table_valid[page_q] <= 1'b1;
            if (frames_left) begin
              frame_q     <= alloc_frame;
              frames_used <= frames_used + 1'b1;
              if (frames_used == '0) begin
                head  <= alloc_frame;
                tail  <= alloc_frame;
                state <= S_FILL;
              end else begin
                state <= S_T2;
              end
            end else begin
              frame_q <= tail;
              state   <= S_EVICT;
            end
          end
        end
        S_EVICT: begin
          evv_q                 <= 1'b1;
          evp_q                 <= ow_rdata;
          table_valid[ow_rdata] <= 1'b0;
          if (stat.drop_hit) begin
            tlb_used <= tlb_used - 1'b1;
          end
          state <= S_T0;
        end
        S_T0: begin
          if (frame_q == head) begin
            state <= hit_q ? S_DONE : S_FILL;
          end else begin
            state <= S_T1;
          end
        end
        S_T1: begin
          if (frame_q == tail) begin
            tail <= pv_rdata;
          end
          state <= S_T2;
        end
        S_T2: begin
          head  <= frame_q;
          state <= hit_q ? S_DONE : S_FILL;
        end
        S_FILL: begin
          if (!tlb_full) begin
            tlb_used <= tlb_used + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            physical_address <= {frame_q, off_q};
            tlb_hit          <= hit_q;
            fault_flag       <= fault_q;
            fill_page        <= fault_q ? page_q : '0;
            evicted_valid    <= evv_q;
            evicted_page     <= evv_q ? evp_q : '0;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/tlbpt_checker.sv
// Port-level checks on the translator's result channel, bound to the top.
// Depends on assert_macros.svh and tlbpt_pkg.
`include "assert_macros.svh"

module tlbpt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tlbpt_pkg::ADDR_W-1:0] physical_address,
  input logic                         tlb_hit,
  input logic                         fault_flag,
  input logic [tlbpt_pkg::PAGE_W-1:0] fill_page,
  input logic                         evicted_valid,
  input logic [tlbpt_pkg::PAGE_W-1:0] evicted_page
);

  // A stalled result stays and holds its address
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `CHK_NEXT(a_out_stable, out_valid && out_stall, $stable(physical_address))

  // A TLB hit never faults
  `CHK_NOW(a_hit_no_fault, out_valid && tlb_hit, !fault_flag && !evicted_valid)

  // Eviction only happens as part of a fault
  `CHK_NOW(a_evict_fault, out_valid && evicted_valid, fault_flag)

  // Without a fault there is nothing to load or evict
  `CHK_NOW(a_quiet_fields, out_valid && !fault_flag,
           fill_page == '0 && evicted_page == '0)

endmodule

bind tlb_page_table_lru_translator tlbpt_checker u_tlbpt_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .physical_address (physical_address),
  .tlb_hit          (tlb_hit),
  .fault_flag       (fault_flag),
  .fill_page        (fill_page),
  .evicted_valid    (evicted_valid),
  .evicted_page     (evicted_page)
);
